// ===== hdl/jrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrc_pkg
// shared types, constants and the crc-32c byte update for the journal checker
// ----------------------------------------------------------------------------
package jrc_pkg;

	// fixed field widths
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 16;
	localparam int SEQ_W     = 64;
	localparam int HLEN_W    = 32;
	localparam int CRC_W     = 32;
	localparam int REC_LEN_W = 24;
	localparam int CFG_W     = 24;
	localparam int EVENT_W   = 2;
	localparam int ERR_W     = 3;
	localparam int HCNT_W    = 5;

	// defaults for the top level parameters
	localparam int DEF_LENGTH_BITS = 24;

	// header layout
	localparam logic [HCNT_W-1:0] HDR_MAGIC_END = 5'd4;
	localparam logic [HCNT_W-1:0] HDR_VER_END   = 5'd6;
	localparam logic [HCNT_W-1:0] HDR_KIND_END  = 5'd8;
	localparam logic [HCNT_W-1:0] HDR_SEQ_END   = 5'd16;
	localparam logic [HCNT_W-1:0] HDR_LEN_END   = 5'd20;
	localparam logic [HCNT_W-1:0] HDR_LAST      = 5'd23;

	localparam logic [31:0]      JMAGIC      = 32'h314A_4D4C;
	localparam logic [15:0]      JVERSION    = 16'h0001;
	localparam logic [CRC_W-1:0] CRC_POLY    = 32'h82F6_3B78;
	localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [CFG_W-1:0] MAX_LEN_RST = 24'h80_0000;

	// result buffer
	localparam int RES_DEPTH = 8;
	localparam int RES_PTR_W = 3;
	localparam int RES_CNT_W = 4;
	localparam int RES_SLACK = 4;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_HALT    = 2'd2
	} phase_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_BYTE   = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_ERROR  = 2'd2,
		EV_END    = 2'd3
	} event_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_SHORT_HDR = 3'd1,
		ERR_MAGIC     = 3'd2,
		ERR_SEQ_GAP   = 3'd3,
		ERR_LENGTH    = 3'd4,
		ERR_SHORT_PAY = 3'd5,
		ERR_CRC       = 3'd6
	} err_t;

	typedef struct packed {
		logic [EVENT_W-1:0]   event_res;
		logic [BYTE_W-1:0]    payload_byte;
		logic [KIND_W-1:0]    record_kind;
		logic [SEQ_W-1:0]     record_sequence;
		logic [REC_LEN_W-1:0] record_length;
		logic [ERR_W-1:0]     error_code;
	} res_t;

	// up to two results per request
	typedef struct packed {
		logic v0;
		res_t r0;
		logic v1;
		res_t r1;
	} push_t;

	// reflected crc-32c over one byte, eight shift steps
	function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
	                                                 input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/jrc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrc_if
// valid/ready channels for the journal checker: byte input, results, limit
// ----------------------------------------------------------------------------
interface jrc_in_if;
	import jrc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_value;
	logic              end_of_stream;
	modport source (output valid, output byte_value, output end_of_stream, input ready);
	modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface jrc_out_if;
	import jrc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [EVENT_W-1:0]   event_res;
	logic [BYTE_W-1:0]    payload_byte;
	logic [KIND_W-1:0]    record_kind;
	logic [SEQ_W-1:0]     record_sequence;
	logic [REC_LEN_W-1:0] record_length;
	logic [ERR_W-1:0]     error_code;
	modport source (output valid, output event_res, output payload_byte, output record_kind,
		output record_sequence, output record_length, output error_code, input ready);
	modport sink   (input valid, input event_res, input payload_byte, input record_kind,
		input record_sequence, input record_length, input error_code, output ready);
endinterface

interface jrc_cfg_if;
	import jrc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] max_payload_length;
	modport source (output valid, output max_payload_length, input ready);
	modport sink   (input valid, input max_payload_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/journal_record_checker_crc32c.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: a byte request is accepted into the input register, its results are written into the
// result buffer, and the buffer head is offered on the output from there
// throughput: one byte request per cycle while ready is high; the last payload byte of a record yields two
// results, drained one per cycle from an eight-entry result buffer that lowers ready
// once more than four results are waiting
// reset: asynchronous, active low; clears parser state and halt, limit back to 8388608
// ----------------------------------------------------------------------------
// journal_record_checker_crc32c
// journal byte stream parser: 24-byte header checks, payload pass-through with
// running crc-32c, record accept, clean end or error report, halt on end or first error
// ----------------------------------------------------------------------------
module journal_record_checker_crc32c #(
	parameter int LENGTH_BITS = jrc_pkg::DEF_LENGTH_BITS
) (
	input wire logic   clk,
	input wire logic   arst_n,
	jrc_in_if.sink     in_ch,
	jrc_out_if.source  out_ch,
	jrc_cfg_if.sink    cfg_ch
);
	import jrc_pkg::*;

	// payload length limit, always writable
	logic [CFG_W-1:0] max_len_q;
	// pushes from the parser into the result buffer
	push_t            push;
	// buffer has room for the request in flight plus a new one
	logic             space_ok;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_ch.valid) begin
			max_len_q <= cfg_ch.max_payload_length;
		end
	end

	// input register, header checks and payload crc in one pass
	jrc_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.space_ok (space_ok),
		.max_len  (max_len_q),
		.push     (push)
	);

	// result buffer, decouples output stalls from the byte stream
	jrc_res_fifo u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire

// ===== hdl/jrc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrc_core
// input register, header collection and checks, payload crc, result pushes
// ----------------------------------------------------------------------------
module jrc_core #(
	parameter int LENGTH_BITS = jrc_pkg::DEF_LENGTH_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	jrc_in_if.sink                        in_ch,
	input  wire logic                     space_ok,
	input  wire logic [jrc_pkg::CFG_W-1:0] max_len,
	output jrc_pkg::push_t                push
);
	import jrc_pkg::*;

	localparam logic [HLEN_W:0] CAP = (33'd1 << LENGTH_BITS) - 33'd1;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eos_s1;

	phase_t                  phase_q, phase_d;
	logic [HCNT_W-1:0]       hcnt_q, hcnt_d;
	logic                    hok_q, hok_d;
	logic [KIND_W-1:0]       kind_q, kind_d;
	logic [SEQ_W-1:0]        seq_q, seq_d;
	logic [HLEN_W-1:0]       len_q, len_d;
	logic [CRC_W-1:0]        hcrc_q, hcrc_d;
	logic [SEQ_W-1:0]        expect_q, expect_d;
	logic [CRC_W-1:0]        crc_q, crc_d;
	logic [LENGTH_BITS-1:0]  left_q, left_d;
	logic [CRC_W-1:0]        crc_nx;
	logic                    byte_ok;

	assign in_ch.ready = space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_ch.valid & in_ch.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid & in_ch.ready) begin
			byte_s1 <= in_ch.byte_value;
			eos_s1  <= in_ch.end_of_stream;
		end
	end

	function automatic res_t mk_res(input event_t ev, input logic [BYTE_W-1:0] pb,
	                                input logic fld, input err_t err,
	                                input logic [KIND_W-1:0] k, input logic [SEQ_W-1:0] s,
	                                input logic [HLEN_W-1:0] l);
		res_t r;
		r.event_res       = ev;
		r.payload_byte    = pb;
		r.record_kind     = fld ? k : '0;
		r.record_sequence = fld ? s : '0;
		r.record_length   = fld ? l[REC_LEN_W-1:0] : '0;
		r.error_code      = err;
		return r;
	endfunction

	assign crc_nx = crc32c_byte(crc_q, byte_s1);

	always_comb begin
		phase_d  = phase_q;
		hcnt_d   = hcnt_q;
		hok_d    = hok_q;
		kind_d   = kind_q;
		seq_d    = seq_q;
		len_d    = len_q;
		hcrc_d   = hcrc_q;
		expect_d = expect_q;
		crc_d    = crc_q;
		left_d   = left_q;
		byte_ok  = 1'b1;
		push     = '0;
		if (valid_s1) begin
			case (phase_q)
				PH_HEADER: begin
					if (eos_s1) begin
						push.v0 = 1'b1;
						if (hcnt_q == '0) begin
							push.r0 = mk_res(EV_END, '0, 1'b0, ERR_NONE, kind_q, seq_q, len_q);
						end else begin
							push.r0 = mk_res(EV_ERROR, '0, 1'b0, ERR_SHORT_HDR,
								kind_q, seq_q, len_q);
						end
						phase_d = PH_HALT;
					end else begin
						// field capture by header offset
						if (hcnt_q < HDR_MAGIC_END) begin
							byte_ok = byte_s1 == JMAGIC[8*hcnt_q[1:0] +: 8];
						end else if (hcnt_q < HDR_VER_END) begin
							byte_ok = byte_s1 == JVERSION[8*hcnt_q[0] +: 8];
						end else if (hcnt_q < HDR_KIND_END) begin
							kind_d[8*hcnt_q[0] +: 8] = byte_s1;
						end else if (hcnt_q < HDR_SEQ_END) begin
							seq_d[8*hcnt_q[2:0] +: 8] = byte_s1;
						end else if (hcnt_q < HDR_LEN_END) begin
							len_d[8*hcnt_q[1:0] +: 8] = byte_s1;
						end else begin
							hcrc_d[8*hcnt_q[1:0] +: 8] = byte_s1;
						end
						hok_d = ((hcnt_q == '0) ? 1'b1 : hok_q) & byte_ok;
						if (hcnt_q != HDR_LAST) begin
							hcnt_d = hcnt_q + 1'b1;
						end else begin
							hcnt_d = '0;
							if (!hok_d) begin
								push.v0 = 1'b1;
								push.r0 = mk_res(EV_ERROR, '0, 1'b1, ERR_MAGIC,
									kind_d, seq_d, len_d);
								phase_d = PH_HALT;
							end else if (seq_d != expect_q) begin
								push.v0 = 1'b1;
								push.r0 = mk_res(EV_ERROR, '0, 1'b1, ERR_SEQ_GAP,
									kind_d, seq_d, len_d);
								phase_d = PH_HALT;
							end else if (len_d == '0 ||
							             len_d > {{(HLEN_W-CFG_W){1'b0}}, max_len} ||
							             {1'b0, len_d} > CAP) begin
								push.v0 = 1'b1;
								push.r0 = mk_res(EV_ERROR, '0, 1'b1, ERR_LENGTH,
									kind_d, seq_d, len_d);
								phase_d = PH_HALT;
							end else begin
								left_d  = len_d[LENGTH_BITS-1:0];
								crc_d   = CRC_INIT;
								phase_d = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					push.v0 = 1'b1;
					if (eos_s1) begin
						push.r0 = mk_res(EV_ERROR, '0, 1'b1, ERR_SHORT_PAY, kind_q, seq_q, len_q);
						phase_d = PH_HALT;
					end else begin
						crc_d   = crc_nx;
						push.r0 = mk_res(EV_BYTE, byte_s1, 1'b1, ERR_NONE, kind_q, seq_q, len_q);
						left_d  = left_q - 1'b1;
						if (left_d == '0) begin
							push.v1 = 1'b1;
							if (~crc_nx == hcrc_q) begin
								push.r1  = mk_res(EV_ACCEPT, '0, 1'b1, ERR_NONE,
									kind_q, seq_q, len_q);
								expect_d = seq_q + 1'b1;
								hcnt_d   = '0;
								phase_d  = PH_HEADER;
							end else begin
								push.r1 = mk_res(EV_ERROR, '0, 1'b1, ERR_CRC,
									kind_q, seq_q, len_q);
								phase_d = PH_HALT;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcnt_q   <= '0;
			hok_q    <= 1'b1;
			kind_q   <= '0;
			seq_q    <= '0;
			len_q    <= '0;
			hcrc_q   <= '0;
			expect_q <= {{(SEQ_W-1){1'b0}}, 1'b1};
			crc_q    <= CRC_INIT;
			left_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			hcnt_q   <= hcnt_d;
			hok_q    <= hok_d;
			kind_q   <= kind_d;
			seq_q    <= seq_d;
			len_q    <= len_d;
			hcrc_q   <= hcrc_d;
			expect_q <= expect_d;
			crc_q    <= crc_d;
			left_q   <= left_d;
		end
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("left halt without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |-> !push.v0 && !push.v1)
		else $error("result pushed while halted");

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && phase_q == PH_PAYLOAD)
		else $error("second result without first");

endmodule
`default_nettype wire

// ===== hdl/jrc_res_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrc_res_fifo
// result buffer taking up to two results per cycle, draining one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module jrc_res_fifo (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  jrc_pkg::push_t push,
	output logic       space_ok,
	jrc_out_if.source  out_ch
);
	import jrc_pkg::*;

	res_t                 mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_nx;
	logic [RES_CNT_W-1:0] cnt_q, n_push;
	logic                 pop;
	res_t                 head;

	assign wr_nx  = wr_ptr_q + 1'b1;
	assign pop    = out_ch.valid & out_ch.ready;
	assign n_push = {{(RES_CNT_W-1){1'b0}}, push.v0} + {{(RES_CNT_W-1){1'b0}}, push.v1};
	// room for the request in the input stage and one more
	assign space_ok = cnt_q <= RES_CNT_W'(RES_DEPTH - RES_SLACK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[RES_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + n_push - {{(RES_CNT_W-1){1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_nx] <= push.r1;
		end
	end

	assign head                   = mem_q[rd_ptr_q];
	assign out_ch.valid           = cnt_q != '0;
	assign out_ch.event_res       = head.event_res;
	assign out_ch.payload_byte    = head.payload_byte;
	assign out_ch.record_kind     = head.record_kind;
	assign out_ch.record_sequence = head.record_sequence;
	assign out_ch.record_length   = head.record_length;
	assign out_ch.error_code      = head.error_code;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result buffer overflow");

endmodule
`default_nettype wire

// ===== tb/journal_record_checker_crc32c_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_record_checker_crc32c_test
// self-checking bench for the journal record checker: a short table of
// hand-picked records, then random well-formed journals over several payload
// limits, ending in one randomly chosen clean end or fault. every result is
// compared field by field with an in-bench prediction of the parser
// ----------------------------------------------------------------------------
module journal_record_checker_crc32c_test;
	import jrc_pkg::*;

	// bench timing
	localparam int HOLD_CYCLES    = 200;   // long receiver stall, fills the result buffer
	localparam int SETTLE_CYCLES  = 8;     // covers the input register and result buffer, plus margin
	localparam int DRAIN_LIMIT    = 1000;  // cycles allowed for outstanding results
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
	localparam int PRINT_LIMIT    = 50;
	localparam longint unsigned LEN_CAP = (64'd1 << DEF_LENGTH_BITS) - 64'd1;

	// payload content patterns
	typedef enum logic [1:0] {
		FILL_RANDOM = 2'd0,
		FILL_ZERO   = 2'd1,
		FILL_ONES   = 2'd2,
		FILL_COUNT  = 2'd3   // ascii '1', '2', ... so nine bytes give the crc check string
	} fill_t;

	// how the journal ends; only one per run, as any of them halts the block
	typedef enum int {
		FIN_CLEAN,
		FIN_SHORT_HDR,
		FIN_MAGIC,
		FIN_VERSION,
		FIN_SEQ_GAP,
		FIN_LEN_ZERO,
		FIN_LEN_OVER,
		FIN_LEN_WIDE,
		FIN_ZERO_LIMIT,
		FIN_SHORT_PAY,
		FIN_CRC
	} finale_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [REC_LEN_W-1:0] len;
		fill_t                fill;
		logic                 typed;   // accept result written out by hand
	} directed_row_t;

	// hand-picked records, all accepted; kind and byte extremes, and the
	// standard crc-32c check string as a payload
	localparam directed_row_t DIRECTED_ROWS [0:2] = '{
		'{16'h0000, 24'd1, FILL_ZERO,  1'b1},
		'{16'hFFFF, 24'd1, FILL_ONES,  1'b1},
		'{16'h8001, 24'd9, FILL_COUNT, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n;

	jrc_in_if  in_ch ();
	jrc_out_if out_ch ();
	jrc_cfg_if cfg_ch ();

	journal_record_checker_crc32c dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// parser prediction: a private copy of the block's state
	// ------------------------------------------------------------------
	phase_t            walk_phase = PH_HEADER;
	logic [4:0]        hdr_idx    = '0;
	bit                hdr_good   = 1'b1;
	logic [15:0]       cur_kind   = '0;
	logic [63:0]       cur_seq    = '0;
	logic [31:0]       cur_len    = '0;
	logic [31:0]       cur_crc    = '0;
	logic [63:0]       last_seq   = '0;   // sequence of the last accepted record
	logic [31:0]       crc_acc    = CRC_INIT;
	logic [23:0]       remaining  = '0;
	logic [CFG_W-1:0]  limit_reg  = MAX_LEN_RST;

	// results still owed by the block, oldest first
	res_t pending_results [$];

	// a hand-written closing result, used in place of the predicted one
	res_t tabled_close;
	bit   tabled_set = 1'b0;

	int  mismatch_count = 0;
	int  results_seen   = 0;
	int  bytes_counted  = 0;   // requests that reached a running parser
	int  gap_odds       = 0;   // 0: sender never idles
	bit  calm           = 1'b0;
	bit  hold_pending   = 1'b0;
	int  idle_cycles    = 0;

	function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic res_t build_result(input event_t ev, input logic [7:0] pb,
		input logic [15:0] kind, input logic [63:0] seq, input logic [23:0] len,
		input err_t err);
		res_t r;
		r.event_res       = ev;
		r.payload_byte    = pb;
		r.record_kind     = kind;
		r.record_sequence = seq;
		r.record_length   = len;
		r.error_code      = err;
		return r;
	endfunction

	task automatic queue_result(input event_t ev, input logic [7:0] pb, input bit with_fields,
		input err_t err);
		res_t r;
		if (with_fields)
			r = build_result(ev, pb, cur_kind, cur_seq, cur_len[23:0], err);
		else
			r = build_result(ev, pb, '0, '0, '0, err);
		// a row of the table may fix the next closing result by hand
		if (ev != EV_BYTE && tabled_set) begin
			r = tabled_close;
			tabled_set = 1'b0;
		end
		pending_results = {pending_results, r};
	endtask

	// one accepted byte request through the parser
	task automatic predict_journal_byte(input logic [7:0] b, input logic eos);
		int k;
		logic [31:0] word;
		if (walk_phase == PH_HALT)
			return;
		if (walk_phase == PH_HEADER) begin
			k = int'(hdr_idx);
			if (eos) begin
				// nothing collected yet: clean end, otherwise a cut-off header
				if (k == 0)
					queue_result(EV_END, 8'h00, 1'b0, ERR_NONE);
				else
					queue_result(EV_ERROR, 8'h00, 1'b0, ERR_SHORT_HDR);
				walk_phase = PH_HALT;
				return;
			end
			if (k == 0)
				hdr_good = 1'b1;
			if (k < HDR_MAGIC_END) begin
				word = JMAGIC >> (8 * k);
				if (b != word[7:0])
					hdr_good = 1'b0;
			end else if (k < HDR_VER_END) begin
				word = {16'd0, JVERSION} >> (8 * (k - HDR_MAGIC_END));
				if (b != word[7:0])
					hdr_good = 1'b0;
			end else if (k < HDR_KIND_END) begin
				cur_kind[8 * (k - HDR_VER_END) +: 8] = b;
			end else if (k < HDR_SEQ_END) begin
				cur_seq[8 * (k - HDR_KIND_END) +: 8] = b;
			end else if (k < HDR_LEN_END) begin
				cur_len[8 * (k - HDR_SEQ_END) +: 8] = b;
			end else begin
				cur_crc[8 * (k - HDR_LEN_END) +: 8] = b;
			end
			if (k < HDR_LAST) begin
				hdr_idx = 5'(k + 1);
				return;
			end
			hdr_idx = '0;
			// checks in fixed priority: identity, sequence, length
			if (!hdr_good) begin
				queue_result(EV_ERROR, 8'h00, 1'b1, ERR_MAGIC);
				walk_phase = PH_HALT;
			end else if (cur_seq != last_seq + 64'd1) begin
				queue_result(EV_ERROR, 8'h00, 1'b1, ERR_SEQ_GAP);
				walk_phase = PH_HALT;
			end else if (cur_len == 0 || cur_len > limit_reg || cur_len > LEN_CAP) begin
				queue_result(EV_ERROR, 8'h00, 1'b1, ERR_LENGTH);
				walk_phase = PH_HALT;
			end else begin
				remaining  = cur_len[23:0];
				crc_acc    = CRC_INIT;
				walk_phase = PH_PAYLOAD;
			end
			return;
		end
		// payload phase
		if (eos) begin
			queue_result(EV_ERROR, 8'h00, 1'b1, ERR_SHORT_PAY);
			walk_phase = PH_HALT;
			return;
		end
		crc_acc = crc32c_step(crc_acc, b);
		queue_result(EV_BYTE, b, 1'b1, ERR_NONE);
		remaining = remaining - 24'd1;
		if (remaining != 0)
			return;
		if (~crc_acc == cur_crc) begin
			queue_result(EV_ACCEPT, 8'h00, 1'b1, ERR_NONE);
			last_seq   = cur_seq;
			walk_phase = PH_HEADER;
			hdr_idx    = '0;
		end else begin
			queue_result(EV_ERROR, 8'h00, 1'b1, ERR_CRC);
			walk_phase = PH_HALT;
		end
	endtask

	// ------------------------------------------------------------------
	// reporting and result checking
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what,
				got, want);
		mismatch_count++;
	endtask

	// every result taken from the block is held against the oldest one owed
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = build_result(event_t'(out_ch.event_res), out_ch.payload_byte,
				out_ch.record_kind, out_ch.record_sequence, out_ch.record_length,
				err_t'(out_ch.error_code));
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result, event", 64'(got.event_res), '0);
			end else begin
				want = pending_results.pop_front();
				if (got.event_res !== want.event_res)
					flag_mismatch("event_res", 64'(got.event_res), 64'(want.event_res));
				if (got.payload_byte !== want.payload_byte)
					flag_mismatch("payload_byte", 64'(got.payload_byte),
						64'(want.payload_byte));
				if (got.record_kind !== want.record_kind)
					flag_mismatch("record_kind", 64'(got.record_kind),
						64'(want.record_kind));
				if (got.record_sequence !== want.record_sequence)
					flag_mismatch("record_sequence", got.record_sequence,
						want.record_sequence);
				if (got.record_length !== want.record_length)
					flag_mismatch("record_length", 64'(got.record_length),
						64'(want.record_length));
				if (got.error_code !== want.error_code)
					flag_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
			end
			results_seen++;
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("** journal_record_checker_crc32c: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// result receiver: random stalls, one long hold on request, none once calm
	// ------------------------------------------------------------------
	initial begin
		forever begin
			if (hold_pending) begin
				// long hold counted here, while the sender keeps offering
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_pending = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------
	task automatic pause_sender(input int cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// one byte request; valid stays high afterwards unless the next call idles
	task automatic offer_byte(input logic [7:0] b, input logic eos);
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
			pause_sender($urandom_range(1, 12));
		in_ch.valid         <= 1'b1;
		in_ch.byte_value    <= b;
		in_ch.end_of_stream <= eos;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (walk_phase != PH_HALT)
			bytes_counted++;
		predict_journal_byte(b, eos);
	endtask

	// wait until every owed result has come, then let the pipeline empty
	task automatic settle_block();
		int waited;
		waited = 0;
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_payload_limit(input logic [CFG_W-1:0] value);
		cfg_ch.valid              <= 1'b1;
		cfg_ch.max_payload_length <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		limit_reg = value;
	endtask

	// header plus payload; spoil_bit flips a magic or version bit, cut_at puts
	// the end marker at that stream position instead of a byte
	task automatic send_record(input logic [15:0] kind, input logic [63:0] seq,
		input logic [31:0] len, input fill_t fill, input int spoil_bit, input bit bad_crc,
		input int cut_at);
		logic [191:0] hv;
		logic [7:0]   body [];
		logic [31:0]  crc;
		int           n_body;
		n_body = (len <= 32'd4096) ? int'(len) : 0;
		body   = new[n_body];
		crc    = CRC_INIT;
		for (int i = 0; i < n_body; i++) begin
			case (fill)
				FILL_ZERO:  body[i] = 8'h00;
				FILL_ONES:  body[i] = 8'hFF;
				FILL_COUNT: body[i] = 8'h31 + 8'(i);
				default:    body[i] = 8'($urandom_range(0, 255));
			endcase
			crc = crc32c_step(crc, body[i]);
		end
		crc = ~crc;
		if (bad_crc)
			crc[$urandom_range(0, 31)] ^= 1'b1;
		// little-endian header, magic in the lowest byte
		hv = {crc, len, seq, kind, JVERSION, JMAGIC};
		if (spoil_bit >= 0)
			hv[spoil_bit] = ~hv[spoil_bit];
		for (int i = 0; i < 24; i++) begin
			if (i == cut_at) begin
				offer_byte(8'($urandom_range(0, 255)), 1'b1);
				return;
			end
			offer_byte(hv[8 * i +: 8], 1'b0);
		end
		// payload only goes out if the header got the parser there
		for (int i = 0; i < n_body && walk_phase == PH_PAYLOAD; i++) begin
			if (24 + i == cut_at) begin
				offer_byte(8'($urandom_range(0, 255)), 1'b1);
				return;
			end
			offer_byte(body[i], 1'b0);
		end
	endtask

	// mostly short payloads, now and then a few hundred bytes, never over the limit
	function automatic logic [31:0] pick_length();
		logic [31:0] top;
		top = (limit_reg < 24'd16) ? 32'(limit_reg) : 32'd16;
		if ($urandom_range(0, 11) == 0)
			top = (limit_reg < 24'd300) ? 32'(limit_reg) : 32'd300;
		return $urandom_range(1, top);
	endfunction

	function automatic fill_t pick_fill();
		case ($urandom_range(0, 9))
			0:       return FILL_ZERO;
			1:       return FILL_ONES;
			default: return FILL_RANDOM;
		endcase
	endfunction

	// well-formed record with random kind and content, next sequence number
	task automatic send_good_record();
		send_record(16'($urandom), last_seq + 64'd1, pick_length(), pick_fill(), -1, 1'b0,
			-1);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int              goal;
		logic [CFG_W-1:0] lim;
		finale_t         finale;
		logic [63:0]     seq;
		logic [31:0]     len;

		arst_n                    <= 1'b0;
		in_ch.valid               <= 1'b0;
		in_ch.byte_value          <= '0;
		in_ch.end_of_stream       <= 1'b0;
		cfg_ch.valid              <= 1'b0;
		cfg_ch.max_payload_length <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed records at the reset limit
		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].typed) begin
				tabled_close = build_result(EV_ACCEPT, 8'h00, DIRECTED_ROWS[i].kind,
					last_seq + 64'd1, DIRECTED_ROWS[i].len, ERR_NONE);
				tabled_set = 1'b1;
			end
			send_record(DIRECTED_ROWS[i].kind, last_seq + 64'd1, 32'(DIRECTED_ROWS[i].len),
				DIRECTED_ROWS[i].fill, -1, 1'b0, -1);
		end

		// random well-formed journals over a run of payload limits, the
		// extremes first; the block is idle before each limit write
		for (int ph = 0; ph < 6; ph++) begin
			settle_block();
			case (ph)
				0:       lim = 24'd1;
				1:       lim = 24'hFF_FFFF;
				2:       lim = MAX_LEN_RST;
				3:       lim = 24'($urandom_range(1, 32));
				default: lim = 24'($urandom_range(1, 500));
			endcase
			write_payload_limit(lim);
			case ($urandom_range(0, 2))
				0:       gap_odds = 0;
				1:       gap_odds = 3;
				default: gap_odds = 9;
			endcase
			if (ph == 2) begin
				// receiver holds off, sender keeps going until input stalls
				gap_odds     = 0;
				hold_pending = 1'b1;
			end
			goal = bytes_counted + 120;
			while (bytes_counted < goal)
				send_good_record();
		end

		// last stretch: no idling either side, then one way of ending
		settle_block();
		calm     = 1'b1;
		gap_odds = 0;
		write_payload_limit(24'($urandom_range(1, 8388608)));
		goal = bytes_counted + 80;
		while (bytes_counted < goal)
			send_good_record();

		finale = finale_t'($urandom_range(0, FIN_CRC));
		len    = pick_length();
		case (finale)
			FIN_CLEAN: begin
				tabled_close = build_result(EV_END, 8'h00, '0, '0, '0, ERR_NONE);
				tabled_set   = 1'b1;
				offer_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			FIN_SHORT_HDR: begin
				tabled_close = build_result(EV_ERROR, 8'h00, '0, '0, '0, ERR_SHORT_HDR);
				tabled_set   = 1'b1;
				send_record(16'($urandom), last_seq + 64'd1, len, FILL_RANDOM, -1, 1'b0,
					$urandom_range(1, 23));
			end
			FIN_MAGIC:
				send_record(16'($urandom), last_seq + 64'd1, len, FILL_RANDOM,
					$urandom_range(0, 31), 1'b0, -1);
			FIN_VERSION:
				send_record(16'($urandom), last_seq + 64'd1, len, FILL_RANDOM,
					$urandom_range(32, 47), 1'b0, -1);
			FIN_SEQ_GAP: begin
				// a repeated sequence or a wild one
				seq = $urandom_range(0, 1) ? last_seq : {$urandom, $urandom};
				if (seq == last_seq + 64'd1)
					seq = seq + 64'd1;
				send_record(16'($urandom), seq, len, FILL_RANDOM, -1, 1'b0, -1);
			end
			FIN_LEN_ZERO:
				send_record(16'($urandom), last_seq + 64'd1, 32'd0, FILL_RANDOM, -1, 1'b0, -1);
			FIN_LEN_OVER:
				send_record(16'($urandom), last_seq + 64'd1, 32'(limit_reg) + 32'd1,
					FILL_RANDOM, -1, 1'b0, -1);
			FIN_LEN_WIDE:
				// length that does not fit the payload counter at all
				send_record(16'($urandom), last_seq + 64'd1,
					{8'($urandom_range(1, 255)), 24'($urandom)}, FILL_RANDOM, -1, 1'b0, -1);
			FIN_ZERO_LIMIT: begin
				settle_block();
				write_payload_limit('0);
				send_record(16'($urandom), last_seq + 64'd1, $urandom_range(1, 16),
					FILL_RANDOM, -1, 1'b0, -1);
			end
			FIN_SHORT_PAY:
				send_record(16'($urandom), last_seq + 64'd1, len, FILL_RANDOM, -1, 1'b0,
					24 + $urandom_range(0, len - 1));
			default:
				send_record(16'($urandom), last_seq + 64'd1, len, FILL_RANDOM, -1, 1'b1, -1);
		endcase

		// the block is halted now: these requests must give nothing
		repeat ($urandom_range(3, 8))
			offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		settle_block();
		if (pending_results.size() != 0)
			flag_mismatch("results never delivered", 64'(pending_results.size()), '0);
		if (mismatch_count == 0)
			$display("** journal_record_checker_crc32c: PASSED **");
		else
			$display("** journal_record_checker_crc32c: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/jrc_pkg.sv
hdl/jrc_if.sv
hdl/jrc_core.sv
hdl/jrc_res_fifo.sv
hdl/journal_record_checker_crc32c.sv
tb/journal_record_checker_crc32c_test.sv
